FILE: design/nearest_palette_color_index_macros.svh
// Assertion macros for the nearest palette color index block.
// Used by the port checker; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_INDEX_MACROS_SVH
`define NEAREST_PALETTE_COLOR_INDEX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NPCI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npci assertion failed");

// Next-cycle implication, disabled during reset.
`define NPCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npci assertion failed");

`endif

FILE: design/npci_pkg.sv
// Shared types, widths and the fixed 32-entry palette ROM.
// No dependencies; used by all design modules.
`timescale 1ns / 1ps

package npci_pkg;

    localparam int NUM_COLORS = 32;
    localparam int IDX_W      = 5;
    localparam int COMP_W     = 8;
    localparam int SQ_W       = 2 * COMP_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int NUM_CHAN   = 3;

    typedef logic [COMP_W-1:0] comp_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef struct packed {
        dist_t total;
        idx_t  idx;
    } cand_t;

    // Load enables for a group of three pipeline stages.
    typedef struct packed {
        logic en_first;
        logic en_mid;
        logic en_last;
    } stage_en_t;

    localparam comp_t PALETTE [NUM_COLORS][NUM_CHAN] = '{
        '{8'd0,   8'd0,   8'd0  }, '{8'd255, 8'd255, 8'd255},
        '{8'd170, 8'd170, 8'd170}, '{8'd85,  8'd85,  8'd85 },
        '{8'd254, 8'd211, 8'd199}, '{8'd255, 8'd196, 8'd206},
        '{8'd250, 8'd172, 8'd142}, '{8'd255, 8'd139, 8'd131},
        '{8'd244, 8'd67,  8'd54 }, '{8'd233, 8'd30,  8'd99 },
        '{8'd226, 8'd102, 8'd158}, '{8'd156, 8'd39,  8'd176},
        '{8'd103, 8'd58,  8'd183}, '{8'd63,  8'd81,  8'd181},
        '{8'd0,   8'd70,  8'd112}, '{8'd5,   8'd113, 8'd151},
        '{8'd33,  8'd150, 8'd243}, '{8'd0,   8'd188, 8'd212},
        '{8'd59,  8'd229, 8'd219}, '{8'd151, 8'd253, 8'd220},
        '{8'd22,  8'd115, 8'd0  }, '{8'd55,  8'd169, 8'd60 },
        '{8'd137, 8'd230, 8'd66 }, '{8'd215, 8'd255, 8'd7  },
        '{8'd255, 8'd246, 8'd209}, '{8'd248, 8'd203, 8'd140},
        '{8'd255, 8'd235, 8'd59 }, '{8'd255, 8'd193, 8'd7  },
        '{8'd255, 8'd152, 8'd0  }, '{8'd255, 8'd87,  8'd34 },
        '{8'd184, 8'd63,  8'd39 }, '{8'd121, 8'd85,  8'd72 }
    };

endpackage

FILE: design/npci_dist.sv
// Squared-distance lanes: abs difference, square, sum, one register stage each.
// Depends on npci_pkg.
`timescale 1ns / 1ps

module npci_dist
(
    input  logic                 clk,
    input  npci_pkg::stage_en_t  en,
    input  npci_pkg::comp_t      red,
    input  npci_pkg::comp_t      green,
    input  npci_pkg::comp_t      blue,
    output npci_pkg::dist_t      lane_dist [npci_pkg::NUM_COLORS]
);

    npci_pkg::comp_t diff_reg [npci_pkg::NUM_COLORS][npci_pkg::NUM_CHAN];
    npci_pkg::comp_t diff_next [npci_pkg::NUM_COLORS][npci_pkg::NUM_CHAN];
    npci_pkg::sq_t   sq_reg   [npci_pkg::NUM_COLORS][npci_pkg::NUM_CHAN];
    npci_pkg::sq_t   sq_next  [npci_pkg::NUM_COLORS][npci_pkg::NUM_CHAN];
    npci_pkg::dist_t dist_reg [npci_pkg::NUM_COLORS];
    npci_pkg::dist_t dist_next [npci_pkg::NUM_COLORS];
    npci_pkg::comp_t pix [npci_pkg::NUM_CHAN];

    assign pix[0] = red;
    assign pix[1] = green;
    assign pix[2] = blue;

    always_comb
    begin
        for (int k = 0; k < npci_pkg::NUM_COLORS; k++)
        begin
            for (int c = 0; c < npci_pkg::NUM_CHAN; c++)
            begin
                diff_next[k][c] = (pix[c] > npci_pkg::PALETTE[k][c])
                                ? pix[c] - npci_pkg::PALETTE[k][c]
                                : npci_pkg::PALETTE[k][c] - pix[c];
                sq_next[k][c]   = npci_pkg::SQ_W'(diff_reg[k][c])
                                * npci_pkg::SQ_W'(diff_reg[k][c]);
            end
            dist_next[k] = npci_pkg::DIST_W'(sq_reg[k][0])
                         + npci_pkg::DIST_W'(sq_reg[k][1])
                         + npci_pkg::DIST_W'(sq_reg[k][2]);
        end
    end

    // Payload stages: advance on enable, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (en.en_first)
        begin
            diff_reg <= diff_next;
        end
        if (en.en_mid)
        begin
            sq_reg <= sq_next;
        end
        if (en.en_last)
        begin
            dist_reg <= dist_next;
        end
    end

    assign lane_dist = dist_reg;

endmodule

FILE: design/npci_min.sv
// Registered minimum tree over 32 distances: 32->8, 8->2, 2->1.
// Ties keep the lower index. Depends on npci_pkg.
`timescale 1ns / 1ps

module npci_min
(
    input  logic                 clk,
    input  npci_pkg::stage_en_t  en,
    input  npci_pkg::dist_t      lane_dist [npci_pkg::NUM_COLORS],
    output npci_pkg::idx_t       best_idx
);

    localparam int L1_N = npci_pkg::NUM_COLORS / 4;
    localparam int L2_N = L1_N / 4;

    npci_pkg::cand_t l1_reg  [L1_N];
    npci_pkg::cand_t l1_next [L1_N];
    npci_pkg::cand_t l2_reg  [L2_N];
    npci_pkg::cand_t l2_next [L2_N];
    npci_pkg::cand_t root;
    npci_pkg::idx_t  idx_reg;
    npci_pkg::idx_t  idx_next;
    npci_pkg::cand_t leaf [npci_pkg::NUM_COLORS];

    // Right side wins only when strictly smaller; left holds the lower indices.
    function automatic npci_pkg::cand_t pick(input npci_pkg::cand_t a,
                                             input npci_pkg::cand_t b);
        return (b.total < a.total) ? b : a;
    endfunction

    always_comb
    begin
        for (int k = 0; k < npci_pkg::NUM_COLORS; k++)
        begin
            leaf[k].total = lane_dist[k];
            leaf[k].idx   = npci_pkg::IDX_W'(k);
        end
        for (int g = 0; g < L1_N; g++)
        begin
            l1_next[g] = pick(pick(leaf[4*g],   leaf[4*g+1]),
                              pick(leaf[4*g+2], leaf[4*g+3]));
        end
        for (int g = 0; g < L2_N; g++)
        begin
            l2_next[g] = pick(pick(l1_reg[4*g],   l1_reg[4*g+1]),
                              pick(l1_reg[4*g+2], l1_reg[4*g+3]));
        end
        root     = pick(l2_reg[0], l2_reg[1]);
        idx_next = root.idx;
    end

    always_ff @(posedge clk)
    begin
        if (en.en_first)
        begin
            l1_reg <= l1_next;
        end
        if (en.en_mid)
        begin
            l2_reg <= l2_next;
        end
        if (en.en_last)
        begin
            idx_reg <= idx_next;
        end
    end

    assign best_idx = idx_reg;

endmodule

FILE: design/nearest_palette_color_index.sv
// out_valid rises when an accepted pixel reaches the last tree register and holds
// while out_stall is high. Throughput: one pixel per cycle unless the pipe is full
// behind a stalled output; all 32 palette distances run in parallel lanes
// and the minimum is found by a three-stage registered compare tree.
// Reset: rst_n clears the stage valid bits; payload registers are not reset.
// Depends on npci_pkg, npci_dist and npci_min.
`timescale 1ns / 1ps

module nearest_palette_color_index
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  npci_pkg::comp_t        red,
    input  npci_pkg::comp_t        green,
    input  npci_pkg::comp_t        blue,
    output logic                   out_valid,
    input  logic                   out_stall,
    output npci_pkg::idx_t         color_index
);

    // Six stages: abs diff, square, sum, tree 32->8, tree 8->2, tree 2->1.
    localparam int NUM_STAGES = 6;

    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   vld_next;
    logic [NUM_STAGES+1:1] en;

    npci_pkg::stage_en_t dist_en;
    npci_pkg::stage_en_t min_en;
    npci_pkg::dist_t     lane_dist [npci_pkg::NUM_COLORS];

    // A stage loads when it is empty or its content moves on this cycle;
    // bubbles collapse so the pipe keeps taking pixels behind a stalled output.
    always_comb
    begin
        en[NUM_STAGES+1] = !out_stall;
        for (int k = NUM_STAGES; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[1] = en[1] ? in_valid : vld_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign dist_en.en_first = en[1];
    assign dist_en.en_mid   = en[2];
    assign dist_en.en_last  = en[3];
    assign min_en.en_first  = en[4];
    assign min_en.en_mid    = en[5];
    assign min_en.en_last   = en[6];

    npci_dist u_dist
    (
        .clk       (clk),
        .en        (dist_en),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .lane_dist (lane_dist)
    );

    npci_min u_min
    (
        .clk       (clk),
        .en        (min_en),
        .lane_dist (lane_dist),
        .best_idx  (color_index)
    );

    // Hold input off only when every stage is full and the output is stalled.
    assign in_stall  = !en[1];
    assign out_valid = vld_reg[NUM_STAGES];

endmodule

FILE: design/npci_checker.sv
// Port-level checker for nearest_palette_color_index, bound to the top level.
// Depends on npci_pkg and nearest_palette_color_index_macros.svh.
`timescale 1ns / 1ps
`include "nearest_palette_color_index_macros.svh"

module npci_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input npci_pkg::comp_t red,
    input npci_pkg::comp_t green,
    input npci_pkg::comp_t blue,
    input logic            out_valid,
    input logic            out_stall,
    input npci_pkg::idx_t  color_index
);

    // Input is held off only behind a full pipe with a stalled result.
    `NPCI_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall)

    // A black pixel accepted with a free-running output comes out as index 0 with out_valid.
    `NPCI_ASSERT_NEXT(a_black_latency, clk, rst_n, in_valid && !in_stall && red == 8'd0 && green == 8'd0 && blue == 8'd0 ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid && color_index == 5'd0)

    // A stalled result stays.
    `NPCI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(color_index))

endmodule

bind nearest_palette_color_index npci_checker u_npci_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_index (color_index)
);

FILE: test/nearest_palette_color_index_checker.sv
// Checker for nearest_palette_color_index: watches both channels, predicts the
// palette index of each accepted pixel and compares it with the returned item.
// Depends on npci_pkg for the port types.
`timescale 1ns / 1ps

module nearest_palette_color_index_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  npci_pkg::comp_t  red,
    input  npci_pkg::comp_t  green,
    input  npci_pkg::comp_t  blue,
    input  logic             out_valid,
    input  logic             out_stall,
    input  npci_pkg::idx_t   color_index,
    output int               mismatch_count,
    output int               pending
);

    typedef struct {
        npci_pkg::comp_t r;
        npci_pkg::comp_t g;
        npci_pkg::comp_t b;
        npci_pkg::idx_t  idx;
    } expected_pick_t;

    // Palette under test, kept apart from the design's copy.
    localparam bit [7:0] SWATCH [32][3] = '{
        '{  0,   0,   0}, '{255, 255, 255}, '{170, 170, 170}, '{ 85,  85,  85},
        '{254, 211, 199}, '{255, 196, 206}, '{250, 172, 142}, '{255, 139, 131},
        '{244,  67,  54}, '{233,  30,  99}, '{226, 102, 158}, '{156,  39, 176},
        '{103,  58, 183}, '{ 63,  81, 181}, '{  0,  70, 112}, '{  5, 113, 151},
        '{ 33, 150, 243}, '{  0, 188, 212}, '{ 59, 229, 219}, '{151, 253, 220},
        '{ 22, 115,   0}, '{ 55, 169,  60}, '{137, 230,  66}, '{215, 255,   7},
        '{255, 246, 209}, '{248, 203, 140}, '{255, 235,  59}, '{255, 193,   7},
        '{255, 152,   0}, '{255,  87,  34}, '{184,  63,  39}, '{121,  85,  72}
    };

    expected_pick_t expected_picks [$];

    initial
    begin
        mismatch_count = 0;
        pending        = 0;
    end

    // Strictly smaller distance wins, so ties keep the lowest index.
    function automatic npci_pkg::idx_t nearest_color(input npci_pkg::comp_t r,
                                                     input npci_pkg::comp_t g,
                                                     input npci_pkg::comp_t b);
        int unsigned    best;
        int unsigned    sq_sum;
        npci_pkg::idx_t best_k;
        int             dr;
        int             dg;
        int             db;
        best   = 32'hFFFF_FFFF;
        best_k = '0;
        for (int k = 0; k < 32; k++)
        begin
            dr     = int'(r) - int'(SWATCH[k][0]);
            dg     = int'(g) - int'(SWATCH[k][1]);
            db     = int'(b) - int'(SWATCH[k][2]);
            sq_sum = dr * dr + dg * dg + db * db;
            if (sq_sum < best)
            begin
                best   = sq_sum;
                best_k = k[4:0];
            end
        end
        return best_k;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        expected_pick_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want.r   = red;
                want.g   = green;
                want.b   = blue;
                want.idx = nearest_color(red, green, blue);
                expected_picks.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_picks.size() == 0)
                    report_mismatch($sformatf("index %0d with no pixel outstanding",
                                              color_index));
                else
                begin
                    want = expected_picks.pop_front();
                    if (color_index !== want.idx)
                        report_mismatch($sformatf("pixel (%0d,%0d,%0d): index %0d, want %0d",
                                                  want.r, want.g, want.b,
                                                  color_index, want.idx));
                end
            end
            pending = expected_picks.size();
        end
    end

endmodule

FILE: test/nearest_palette_color_index_test.sv
// Top of the nearest_palette_color_index testbench: clock, reset, pixel stimulus,
// output back-pressure, watchdog and verdict.
// Depends on npci_pkg, the design and nearest_palette_color_index_checker.
`timescale 1ns / 1ps

module nearest_palette_color_index_test;

    localparam int RANDOM_PIXELS  = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int IDLE_PERCENT   = 14;

    // Directed pixels, packed as {red, green, blue}.
    localparam logic [23:0] DIRECTED [22] = '{
        24'h000000, 24'hFFFFFF,                     // corners of the cube
        24'hFF0000, 24'h00FF00, 24'h0000FF,         // one channel full
        24'h00FFFF, 24'hFF00FF, 24'hFFFF00,         // one channel empty
        24'h808080, 24'h7F7F7F,                     // mid gray, MSB flip
        24'hAA55AA, 24'h55AA55,                     // alternating bits
        24'hFED3C7, 24'hF44336, 24'h795548,         // exact palette colors
        24'hFCE4CE,                                 // tie between entries 4 and 24
        24'h00034C, 24'h01034C,                     // tie between entries 0 and 14
        24'h2A2A2A, 24'h2B2B2B,                     // either side of black / dark gray
        24'hD4D4D4, 24'hD5D5D5                      // either side of light gray / white
    };

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    npci_pkg::comp_t red       = '0;
    npci_pkg::comp_t green     = '0;
    npci_pkg::comp_t blue      = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    npci_pkg::idx_t  color_index;

    int mismatch_count;
    int pending;
    int quiet_cycles = 0;
    bit steady       = 1'b0;   // suppress idling on both sides

    always #6 clk = ~clk;

    nearest_palette_color_index dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_index (color_index)
    );

    nearest_palette_color_index_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .color_index    (color_index),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    // Back-pressure: stall the result side at random, except in the steady stretch.
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL nearest_palette_color_index");
            $finish;
        end
    end

    // Present one pixel, called at a falling edge; return at the falling edge
    // after it is accepted. Idle cycles go in front of the item, never while
    // it waits, so valid stays independent of stall and the payload holds.
    task automatic send_pixel(input npci_pkg::comp_t r,
                              input npci_pkg::comp_t g,
                              input npci_pkg::comp_t b);
        while (!steady && ($urandom_range(99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            red      <= npci_pkg::comp_t'($urandom_range(255));
            green    <= npci_pkg::comp_t'($urandom_range(255));
            blue     <= npci_pkg::comp_t'($urandom_range(255));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        // in_valid is high here, so the first edge without stall takes the item.
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Clamp a jittered component back into 0..255.
    function automatic npci_pkg::comp_t clamp_comp(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return npci_pkg::comp_t'(v);
    endfunction

    initial
    begin
        int              kind;
        int              ka;
        int              kb;
        int              jit;
        npci_pkg::comp_t pix [3];

        // Hold reset, then release it away from the rising edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pixels: extremes, bit patterns, exact hits and ties.
        foreach (DIRECTED[i])
            send_pixel(DIRECTED[i][23:16], DIRECTED[i][15:8], DIRECTED[i][7:0]);

        // Random pixels. Half are uniform over the cube; the rest sit near one
        // palette color or near the midpoint of two, where the nearest choice
        // is close and near-ties are common.
        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            steady = (n >= 250) && (n < 400);
            kind   = $urandom_range(3);
            ka     = $urandom_range(31);
            kb     = $urandom_range(31);
            jit    = (kind == 3) ? 2 : 20;
            for (int c = 0; c < 3; c++)
            begin
                if (kind < 2)
                    pix[c] = npci_pkg::comp_t'($urandom_range(255));
                else if (kind == 2)
                    pix[c] = clamp_comp(int'(npci_pkg::PALETTE[ka][c])
                                        + $urandom_range(2 * jit) - jit);
                else
                    pix[c] = clamp_comp((int'(npci_pkg::PALETTE[ka][c])
                                         + int'(npci_pkg::PALETTE[kb][c])) / 2
                                        + $urandom_range(2 * jit) - jit);
            end
            send_pixel(pix[0], pix[1], pix[2]);
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every expected index, then wait on to catch
        // any stray item. The watchdog bounds the wait.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending == 0)
            $display("PASS nearest_palette_color_index");
        else
            $display("FAIL nearest_palette_color_index");
        $finish;
    end

endmodule
